/* rtl/core/pip_pkg.sv */
// Package for the point-in-polygon crossing-number core.
// Holds field widths, item kinds, register map and the item type passed along the cell chain.
// No dependencies.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_W          = 16;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int IDX_W            = 4;
  localparam int CNT_W            = 5;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd3;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_NONE         = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                      valid;
    kind_t                     kind;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      parity;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
  } item_t;

endpackage

/* rtl/core/pip_edge.sv */
// Three-stage edge crossing unit: differences, products, signed compare and parity update.
// Carries one item along unchanged except for its parity bit.
// Depends on pip_pkg.
module pip_edge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pip_pkg::item_t                     item_i,
  input  logic                               count_i,
  input  logic signed [pip_pkg::COORD_W-1:0] a_x,
  input  logic signed [pip_pkg::COORD_W-1:0] a_y,
  input  logic signed [pip_pkg::COORD_W-1:0] b_x,
  input  logic signed [pip_pkg::COORD_W-1:0] b_y,
  output pip_pkg::item_t                     item_o
);

  pip_pkg::item_t                    item1_r, item2_r, item3_r;
  pip_pkg::item_t                    item3_nxt;
  logic                              cross1_r, cross2_r, cross1_nxt;
  logic                              neg2_r;
  logic signed [pip_pkg::DIFF_W-1:0] dxp1_r, dyb1_r, dyp1_r, dxb1_r;
  logic signed [pip_pkg::DIFF_W-1:0] dxp1_nxt, dyb1_nxt, dyp1_nxt, dxb1_nxt;
  logic signed [pip_pkg::PROD_W-1:0] lhs2_r, rhs2_r;
  logic                              hit;

  always_comb begin
    cross1_nxt = count_i && ((a_y > item_i.y) != (b_y > item_i.y));
    dxp1_nxt   = {item_i.x[pip_pkg::COORD_W-1], item_i.x} - {a_x[pip_pkg::COORD_W-1], a_x};
    dyb1_nxt   = {b_y[pip_pkg::COORD_W-1], b_y} - {a_y[pip_pkg::COORD_W-1], a_y};
    dyp1_nxt   = {item_i.y[pip_pkg::COORD_W-1], item_i.y} - {a_y[pip_pkg::COORD_W-1], a_y};
    dxb1_nxt   = {b_x[pip_pkg::COORD_W-1], b_x} - {a_x[pip_pkg::COORD_W-1], a_x};
  end

  always_comb begin
    hit = cross2_r && (neg2_r ? (lhs2_r > rhs2_r) : (lhs2_r < rhs2_r));
    item3_nxt        = item2_r;
    item3_nxt.parity = item2_r.parity ^ hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item1_r.valid <= 1'b0;
      item2_r.valid <= 1'b0;
      item3_r.valid <= 1'b0;
    end else begin
      item1_r <= item_i;
      item2_r <= item1_r;
      item3_r <= item3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cross1_r <= cross1_nxt;
    dxp1_r   <= dxp1_nxt;
    dyb1_r   <= dyb1_nxt;
    dyp1_r   <= dyp1_nxt;
    dxb1_r   <= dxb1_nxt;
    cross2_r <= cross1_r;
    neg2_r   <= dyb1_r[pip_pkg::DIFF_W-1];
    lhs2_r   <= dxp1_r * dyb1_r;
    rhs2_r   <= dyp1_r * dxb1_r;
  end

  assign item_o = item3_r;

endmodule

/* rtl/core/pip_cell.sv */
// One vertex cell: holds polygon vertex INDEX and, unless INDEX is 0, tests the edge from the previous vertex.
// Loads write the vertex as they pass; queries hand this vertex on as the next edge start.
// Depends on pip_pkg and pip_edge.
module pip_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pip_pkg::CNT_W-1:0]   vertex_count,
  input  pip_pkg::item_t              item_i,
  output pip_pkg::item_t              item_o
);

  logic signed [pip_pkg::COORD_W-1:0] vx_r, vy_r;
  logic                               active;
  logic                               count;
  logic                               load_hit;
  pip_pkg::item_t                     item_mod;

  assign active   = 32'(vertex_count) > 32'(INDEX);
  assign load_hit = item_i.valid && (item_i.kind == pip_pkg::KIND_LOAD) &&
                    (32'(item_i.idx) == 32'(INDEX));
  assign count    = item_i.valid && (item_i.kind == pip_pkg::KIND_QUERY) && active &&
                    (INDEX != 0);

  always_comb begin
    item_mod = item_i;
    if (INDEX == 0) begin
      item_mod.prev_x  = vx_r;
      item_mod.prev_y  = vy_r;
      item_mod.first_x = vx_r;
      item_mod.first_y = vy_r;
    end else if (active) begin
      item_mod.prev_x = vx_r;
      item_mod.prev_y = vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      vx_r <= item_i.x;
      vy_r <= item_i.y;
    end
  end

  pip_edge u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_i  (item_mod),
    .count_i (count),
    .a_x     (item_i.prev_x),
    .a_y     (item_i.prev_y),
    .b_x     (vx_r),
    .b_y     (vy_r),
    .item_o  (item_o)
  );

endmodule

/* rtl/core/point_in_polygon_test_core.sv */
// Point-in-polygon test core (crossing number, horizontal ray toward +x, half-open vertex rule).
// Items enter a chain of MAX_VERTICES vertex cells plus one closing-edge stage; every stage is a
// three-register edge unit, so one item is taken every cycle while busy is low, and a query's
// result strobes on out_valid once it has passed every stage, with no stall on either side.
// Loads travel the same chain and write their vertex when they reach its cell, so each query
// sees exactly the loads transferred before it. busy is high only during and right after reset.
// vertex_count sits at byte address 0 and may be written only while no query is in flight.
// Results cannot be held off; the receiver must take out_inside_res whenever out_valid is high.
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [pip_pkg::IDX_W-1:0]          in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  output logic                               out_inside_res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pip_pkg::APB_AW-1:0]         paddr,
  input  logic [pip_pkg::APB_DW-1:0]         pwdata,
  output logic [pip_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int LATENCY = 3 * (MAX_VERTICES + 1);

  logic                        busy_r;
  logic [pip_pkg::CNT_W-1:0]   vertex_count_r;
  pip_pkg::reg_idx_t           reg_idx;
  logic                        cfg_wr;
  pip_pkg::item_t              item_in;
  pip_pkg::item_t              chain [MAX_VERTICES+1];
  pip_pkg::item_t              item_out;

  assign pready  = 1'b1;
  assign busy    = busy_r;
  assign reg_idx = pip_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      pip_pkg::REG_VERTEX_COUNT: prdata = {{(pip_pkg::APB_DW-pip_pkg::CNT_W){1'b0}},
                                           vertex_count_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b1;
      vertex_count_r <= pip_pkg::VERTEX_COUNT_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr && (reg_idx == pip_pkg::REG_VERTEX_COUNT)) begin
        vertex_count_r <= pwdata[pip_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    item_in         = '0;
    item_in.valid   = start && !busy_r;
    item_in.kind    = pip_pkg::kind_t'(in_kind);
    item_in.idx     = in_vertex_index;
    item_in.x       = in_coord_x;
    item_in.y       = in_coord_y;
  end

  assign chain[0] = item_in;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    pip_cell #(
      .INDEX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .vertex_count (vertex_count_r),
      .item_i       (chain[g]),
      .item_o       (chain[g+1])
    );
  end

  pip_edge u_close (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_i  (chain[MAX_VERTICES]),
    .count_i (chain[MAX_VERTICES].valid && (chain[MAX_VERTICES].kind == pip_pkg::KIND_QUERY)),
    .a_x     (chain[MAX_VERTICES].prev_x),
    .a_y     (chain[MAX_VERTICES].prev_y),
    .b_x     (chain[MAX_VERTICES].first_x),
    .b_y     (chain[MAX_VERTICES].first_y),
    .item_o  (item_out)
  );

  assign out_valid      = item_out.valid && (item_out.kind == pip_pkg::KIND_QUERY);
  assign out_inside_res = item_out.parity;

`ifndef SYNTHESIS
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_kind == pip_pkg::KIND_QUERY), LATENCY))
    else $error("result without a matching query transfer");

  a_bad_addr_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (reg_idx != pip_pkg::REG_VERTEX_COUNT)) |=> $stable(vertex_count_r))
    else $error("write to unmapped address changed vertex_count");

  a_reset_flush: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && busy))
    else $error("pipeline not flushed by reset");
`endif

endmodule
